[rtl/swts_pkg.sv]
// shared types, constants and helpers for the sorted word table search
package swts_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 262144;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int PART_W      = 60;
	localparam int POS_W       = 18;
	localparam int STATUS_W    = 2;

	// item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_HIT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISS   = 2'd3;

	// one stored word, first letters in the high part
	typedef struct packed {
		logic [PART_W-1:0] high;
		logic [PART_W-1:0] mid;
		logic [PART_W-1:0] low;
	} word_t;

	// input word
	typedef struct packed {
		logic              kind;
		logic [PART_W-1:0] key_high;
		logic [PART_W-1:0] key_mid;
		logic [PART_W-1:0] key_low;
	} item_t;

	// result word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
	} result_t;

	// write port of the table store
	typedef struct packed {
		logic              word_we;
		logic              mark_we;
		logic [ADDR_W-1:0] addr;
		word_t             word;
		logic              mark;
	} wr_t;

	// comparator outcome
	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_t;

	// fit a table address into the position field
	function automatic logic [POS_W-1:0] pos_of(input logic [ADDR_W-1:0] addr);
		logic [POS_W+ADDR_W-1:0] ext;
		ext = {{POS_W{1'b0}}, addr};
		return ext[POS_W-1:0];
	endfunction

endpackage

[rtl/swts_store.sv]
// word and found-mark memories with one write port and one registered read port
module swts_store (
	input  logic                        clk,
	input  swts_pkg::wr_t               wr,
	input  logic                        rd_en,
	input  logic [swts_pkg::ADDR_W-1:0] raddr,
	output swts_pkg::word_t             rword,
	output logic                        rmark
);

	swts_pkg::word_t words [swts_pkg::TABLE_DEPTH];
	logic            marks [swts_pkg::TABLE_DEPTH];

	swts_pkg::word_t rword_q;
	logic            rmark_q;

	// writes
	always_ff @(posedge clk) begin
		if (wr.word_we) begin
			words[wr.addr] <= wr.word;
		end
		if (wr.mark_we) begin
			marks[wr.addr] <= wr.mark;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rword_q <= words[raddr];
			rmark_q <= marks[raddr];
		end
	end

	assign rword = rword_q;
	assign rmark = rmark_q;

endmodule

[rtl/swts_cmp.sv]
// shared 180-bit magnitude comparator, key against probed word
module swts_cmp (
	input  swts_pkg::word_t key,
	input  swts_pkg::word_t word,
	output swts_pkg::cmp_t  res
);

	// parts compare as one unsigned number, high part first
	always_comb begin
		res.eq = (key == word);
		res.gt = (key > word);
	end

endmodule

[rtl/sorted_word_table_search_top.sv]
// top level: sorted word table with binary search lookup and found marks
//
//   channel   ports                 handshake
//   input     item (item_t)         taken when start is high and busy is low
//   output    result (result_t)     valid for one cycle while done is high
//
// A load's result shows on the next cycle and busy stays low.
// A lookup repeats a probe, a registered memory read (S_PROBE) and then compare and
// narrow (S_CMP), over the n filled entries until a hit or an empty range ends it.
// A lookup on an empty table answers with a miss without any probe.
// Reset clears the entry count, state and done; stored words and marks stay undefined until loaded.
// The receiver cannot stall: each result is held exactly one cycle.
module sorted_word_table_search_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  swts_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output swts_pkg::result_t result
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_CMP   = 2'd2;

	logic [1:0]                   state_q;
	logic [swts_pkg::CNT_W-1:0]   count_q;
	logic [swts_pkg::CNT_W-1:0]   lo_q;
	logic [swts_pkg::CNT_W-1:0]   end_q;
	logic [swts_pkg::ADDR_W-1:0]  mid_q;
	swts_pkg::word_t              key_q;
	logic                         done_q;
	swts_pkg::result_t            result_q;

	logic [swts_pkg::CNT_W:0]     mid_sum;
	logic [swts_pkg::ADDR_W-1:0]  mid;
	logic [swts_pkg::CNT_W-1:0]   mid_ext;
	logic [swts_pkg::CNT_W-1:0]   lo_next;
	logic [swts_pkg::CNT_W-1:0]   end_next;
	logic                         accept;
	logic                         full;
	logic                         hit;
	swts_pkg::wr_t                wr;
	swts_pkg::word_t              rword;
	logic                         rmark;
	swts_pkg::word_t              in_word;
	swts_pkg::cmp_t               cmp;

	assign accept  = start && (state_q == S_IDLE);
	assign full    = (count_q == swts_pkg::CNT_W'(swts_pkg::TABLE_DEPTH));
	assign in_word = '{high: item.key_high, mid: item.key_mid, low: item.key_low};

	// midpoint of the half-open range [lo, end)
	assign mid_sum = {1'b0, lo_q} + {1'b0, end_q} - {{swts_pkg::CNT_W{1'b0}}, 1'b1};
	assign mid     = mid_sum[swts_pkg::ADDR_W:1];
	assign mid_ext = {{(swts_pkg::CNT_W - swts_pkg::ADDR_W){1'b0}}, mid_q};

	// narrowed range after a probe
	assign hit      = cmp.eq && !rmark;
	assign lo_next  = cmp.gt ? (mid_ext + 1'b1) : lo_q;
	assign end_next = cmp.gt ? end_q : mid_ext;

	// store write port: append on load, set mark on hit
	always_comb begin
		wr         = '0;
		wr.word    = in_word;
		if (state_q == S_CMP) begin
			wr.addr    = mid_q;
			wr.mark_we = hit;
			wr.mark    = 1'b1;
		end else begin
			wr.addr    = count_q[swts_pkg::ADDR_W-1:0];
			wr.word_we = accept && (item.kind == swts_pkg::KIND_LOAD) && !full;
			wr.mark_we = wr.word_we;
			wr.mark    = 1'b0;
		end
	end

	swts_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd_en (state_q == S_PROBE),
		.raddr (mid),
		.rword (rword),
		.rmark (rmark)
	);

	swts_cmp u_cmp (
		.key  (key_q),
		.word (rword),
		.res  (cmp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.kind == swts_pkg::KIND_LOAD) begin
							done_q <= 1'b1;
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit || (lo_next >= end_next)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PROBE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// search range, key and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q <= in_word;
				lo_q  <= '0;
				end_q <= count_q;
				if (item.kind == swts_pkg::KIND_LOAD) begin
					if (full) begin
						result_q <= '{status: swts_pkg::ST_FULL, position: '0};
					end else begin
						result_q <= '{status: swts_pkg::ST_LOADED,
							position: swts_pkg::pos_of(count_q[swts_pkg::ADDR_W-1:0])};
					end
				end else begin
					result_q <= '{status: swts_pkg::ST_MISS, position: '0};
				end
			end
			S_PROBE: begin
				mid_q <= mid;
			end
			S_CMP: begin
				lo_q  <= lo_next;
				end_q <= end_next;
				if (hit) begin
					result_q <= '{status: swts_pkg::ST_HIT,
						position: swts_pkg::pos_of(mid_q)};
				end else begin
					result_q <= '{status: swts_pkg::ST_MISS, position: '0};
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[sim/sorted_word_table_search_checker.sv]
// checker for the sorted word table search: keeps its own table, predicts each answer, compares
`timescale 1ns / 100ps

module sorted_word_table_search_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  swts_pkg::item_t   item,
	input  logic              done,
	input  swts_pkg::result_t result,
	output int                mismatches,
	output int                awaited,
	output int                loads,
	output int                drops,
	output int                lookups,
	output int                hits,
	output int                misses
);
	import swts_pkg::*;

	localparam int WORD_W = 3 * PART_W;

	// shadow copy of the word table and its found marks
	bit [WORD_W-1:0] shadow_word [TABLE_DEPTH];
	bit              shadow_found [TABLE_DEPTH];
	int unsigned     shadow_fill = 0;

	// answers still on their way, oldest first
	result_t answer_q [$];
	result_t want;

	initial begin
		mismatches = 0;
		awaited    = 0;
		loads      = 0;
		drops      = 0;
		lookups    = 0;
		hits       = 0;
		misses     = 0;
	end

	// apply one word to the shadow table and return the answer it must give
	function automatic result_t table_answer(input item_t it);
		result_t         r;
		bit [WORD_W-1:0] key;
		longint          lo;
		longint          hi;
		longint          probe;
		bit              marked;
		r.status   = ST_MISS;
		r.position = '0;
		key        = {it.key_high, it.key_mid, it.key_low};
		if (it.kind == KIND_LOAD) begin
			// append, or drop when every entry is taken
			if (shadow_fill >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_word[shadow_fill]  = key;
				shadow_found[shadow_fill] = 1'b0;
				r.status   = ST_LOADED;
				r.position = shadow_fill[POS_W-1:0];
				shadow_fill++;
			end
		end else begin
			// binary search; an equal but marked entry sends the search left
			lo     = 0;
			hi     = longint'(shadow_fill) - 1;
			marked = 1'b0;
			while (hi >= lo && !marked) begin
				probe = (lo + hi) / 2;
				if (key == shadow_word[probe] && !shadow_found[probe]) begin
					shadow_found[probe] = 1'b1;
					r.status   = ST_HIT;
					r.position = probe[POS_W-1:0];
					marked     = 1'b1;
				end else if (key > shadow_word[probe]) begin
					lo = probe + 1;
				end else begin
					hi = probe - 1;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_fill = 0;
			answer_q.delete();
			awaited = 0;
		end else begin
			// accepted word: predict its answer
			if (start === 1'b1 && busy === 1'b0) begin
				want = table_answer(item);
				answer_q.push_back(want);
				case (want.status)
					ST_LOADED: loads++;
					ST_FULL: begin
						loads++;
						drops++;
					end
					ST_HIT: begin
						lookups++;
						hits++;
					end
					default: begin
						lookups++;
						misses++;
					end
				endcase
			end
			// result word: compare with the oldest prediction
			if (done === 1'b1) begin
				if (answer_q.size() == 0) begin
					$error("result with nothing awaited: status %0d, position %0d",
						result.status, result.position);
					mismatches++;
				end else begin
					want = answer_q.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						mismatches++;
					end
					if (result.position !== want.position) begin
						$error("position: expected %0d, got %0d",
							want.position, result.position);
						mismatches++;
					end
				end
			end
			awaited = answer_q.size();
		end
	end

endmodule

[sim/sorted_word_table_search_top_test.sv]
// testbench top for the sorted word table search: clock, reset, word stimulus and verdict
`timescale 1ns / 100ps

module sorted_word_table_search_top_test;
	import swts_pkg::*;

	localparam int WORD_W       = 3 * PART_W;
	localparam int LETTERS      = 36;
	localparam int RANDOM_ITEMS = 950;
	localparam int FULL_LOOKUPS = 150;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	int mismatches;
	int awaited;
	int loads;
	int drops;
	int lookups;
	int hits;
	int misses;

	// words the table holds, in entry order, for picking lookup keys
	bit [WORD_W-1:0] sent_word [TABLE_DEPTH];
	int unsigned     sent_fill = 0;
	bit [WORD_W-1:0] last_sorted = '0;

	sorted_word_table_search_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	sorted_word_table_search_checker answer_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.awaited    (awaited),
		.loads      (loads),
		.drops      (drops),
		.lookups    (lookups),
		.hits       (hits),
		.misses     (misses)
	);

	always #6 clk = ~clk;

	// hard stop well past the slowest correct run
	initial begin
		#54_000_000;
		$display("run timed out");
		$display("sorted_word_table_search_top: mismatch");
		$finish;
	end

	// letter p of a word, first letter in the top five bits
	function automatic bit [4:0] letter_at(input bit [WORD_W-1:0] w, input int p);
		return w[WORD_W-1-5*p -: 5];
	endfunction

	function automatic bit [WORD_W-1:0] with_letter(input bit [WORD_W-1:0] w, input int p,
		input bit [4:0] c);
		w[WORD_W-1-5*p -: 5] = c;
		return w;
	endfunction

	// upper-case text to packed letter codes
	function automatic bit [WORD_W-1:0] text_word(input string s);
		bit [WORD_W-1:0] w;
		int              i;
		w = '0;
		for (i = 0; i < s.len() && i < LETTERS; i++)
			w = with_letter(w, i, 5'(s[i] - 8'd64));
		return w;
	endfunction

	function automatic bit [WORD_W-1:0] random_bits();
		bit [191:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return r[WORD_W-1:0];
	endfunction

	// next word in dictionary order: raise one letter near the end, random tail after it
	function automatic bit [WORD_W-1:0] next_sorted(input bit [WORD_W-1:0] prev);
		bit [WORD_W-1:0] w;
		int              len;
		int              top;
		int              p;
		int              cand;
		int              tries;
		int              room;
		int              tail;
		int              i;
		bit [4:0]        c;
		len = 0;
		while (len < LETTERS && letter_at(prev, len) != 0)
			len++;
		top = (len < LETTERS) ? len : LETTERS - 1;
		p   = -1;
		for (tries = 0; tries < 4 && p < 0; tries++) begin
			cand = $urandom_range(top, (len > 4) ? len - 4 : 0);
			if (letter_at(prev, cand) < 26)
				p = cand;
		end
		for (cand = top; cand >= 0 && p < 0; cand--)
			if (letter_at(prev, cand) < 26)
				p = cand;
		if (p < 0)
			return prev;
		c    = letter_at(prev, p);
		room = 26 - c;
		w    = with_letter(prev, p, 5'(c + $urandom_range(1, (room < 3) ? room : 3)));
		for (i = p + 1; i < LETTERS; i++)
			w = with_letter(w, i, 5'd0);
		tail = $urandom_range(0, (LETTERS - 1 - p < 2) ? LETTERS - 1 - p : 2);
		for (i = p + 1; i <= p + tail; i++)
			w = with_letter(w, i, 5'($urandom_range(1, 26)));
		return w;
	endfunction

	// offer one word after gap idle cycles and hold it until taken
	task automatic post(input logic kind, input bit [WORD_W-1:0] w, input int gap);
		item_t it;
		it.kind = kind;
		{it.key_high, it.key_mid, it.key_low} = w;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
		if (kind == KIND_LOAD && sent_fill < TABLE_DEPTH) begin
			sent_word[sent_fill] = w;
			sent_fill++;
		end
	endtask

	// a lookup key: mostly stored words, some near misses and noise
	function automatic bit [WORD_W-1:0] lookup_key();
		bit [WORD_W-1:0] w;
		int              roll;
		int              span;
		int              i;
		int              len;
		roll = $urandom_range(0, 99);
		if (sent_fill == 0 || roll >= 80) begin
			if ($urandom_range(0, 1) == 0)
				return random_bits();
			w   = '0;
			len = $urandom_range(1, LETTERS);
			for (i = 0; i < len; i++)
				w = with_letter(w, i, 5'($urandom_range(1, 26)));
			return w;
		end
		if (roll < 45)
			return sent_word[$urandom_range(0, sent_fill - 1)];
		span = (sent_fill < 8) ? sent_fill : 8;
		if (roll < 65)
			return sent_word[sent_fill - 1 - $urandom_range(0, span - 1)];
		// near miss: one letter of a stored word changed
		w = sent_word[$urandom_range(0, sent_fill - 1)];
		return with_letter(w, $urandom_range(0, LETTERS - 1), 5'($urandom_range(0, 26)));
	endfunction

	initial begin
		int              n;
		int              gap;
		int              roll;
		int              p;
		int              span;
		bit              quiet;
		bit [WORD_W-1:0] w;

		// reset
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, duplicates, marked entries, extremes, unsorted load
		post(KIND_LOOKUP, text_word("CAT"), $urandom_range(0, 13));
		post(KIND_LOOKUP, '1, $urandom_range(0, 13));
		post(KIND_LOAD, '0, $urandom_range(0, 13));
		post(KIND_LOAD, text_word("AAB"), $urandom_range(0, 13));
		post(KIND_LOAD, text_word("AAC"), $urandom_range(0, 13));
		post(KIND_LOAD, text_word("AAC"), 0);
		post(KIND_LOAD, text_word("AAD"), $urandom_range(0, 13));
		repeat (3) post(KIND_LOOKUP, text_word("AAC"), $urandom_range(0, 13));
		post(KIND_LOOKUP, '0, 0);
		post(KIND_LOOKUP, text_word("AAD"), $urandom_range(0, 13));
		post(KIND_LOOKUP, '1, $urandom_range(0, 13));
		post(KIND_LOOKUP, text_word("AAA"), 0);
		post(KIND_LOOKUP, {LETTERS{5'd27}}, $urandom_range(0, 13));
		post(KIND_LOAD, text_word("AAA"), $urandom_range(0, 13));
		post(KIND_LOOKUP, text_word("AAA"), $urandom_range(0, 13));
		post(KIND_LOOKUP, {{PART_W{1'b0}}, {2*PART_W{1'b1}}}, 0);
		post(KIND_LOOKUP, {{PART_W{1'b1}}, {2*PART_W{1'b0}}}, $urandom_range(0, 13));
		w = text_word("AAE");
		for (p = 3; p < LETTERS; p++)
			w = with_letter(w, p, 5'd26);
		post(KIND_LOAD, w, $urandom_range(0, 13));
		post(KIND_LOOKUP, w, 0);
		last_sorted = w;

		// random: mostly sorted loads and lookups of stored words
		quiet = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			gap  = quiet ? 0 : $urandom_range(0, 13);
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					post(KIND_LOAD, random_bits(), gap);
				end else if (roll < 8) begin
					post(KIND_LOAD, last_sorted, gap);
				end else begin
					last_sorted = next_sorted(last_sorted);
					post(KIND_LOAD, last_sorted, gap);
				end
			end else begin
				post(KIND_LOOKUP, lookup_key(), gap);
			end
		end

		// closing lookups over the filled entries, ends first
		post(KIND_LOOKUP, sent_word[sent_fill-1], $urandom_range(0, 13));
		post(KIND_LOOKUP, sent_word[0], 0);
		post(KIND_LOOKUP, '1, $urandom_range(0, 13));
		span = (sent_fill < 100) ? sent_fill : 100;
		for (n = 0; n < FULL_LOOKUPS; n++) begin
			gap  = (n < 50) ? 0 : $urandom_range(0, 13);
			roll = $urandom_range(0, 99);
			if (roll < 60)
				post(KIND_LOOKUP, sent_word[$urandom_range(0, sent_fill - 1)], gap);
			else if (roll < 70)
				post(KIND_LOOKUP, sent_word[sent_fill - 1 - $urandom_range(0, span - 1)],
					gap);
			else
				post(KIND_LOOKUP, lookup_key(), gap);
		end
		post(KIND_LOAD, random_bits(), $urandom_range(0, 13));
		start <= 1'b0;

		// drain, then allow for any stray result
		while (awaited != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		$display("covered %0d loads (%0d dropped on a full table) and %0d lookups",
			loads, drops, lookups);
		$display("lookups ended in %0d first-time hits and %0d misses", hits, misses);
		if (mismatches == 0 && awaited == 0)
			$display("sorted_word_table_search_top: match");
		else
			$display("sorted_word_table_search_top: mismatch");
		$finish;
	end

endmodule
